// ----- hw/rtl/spline_efficiency_correction_defines.svh -----
// Assertion macros for the spline efficiency correction block
`ifndef SPLINE_EFFICIENCY_CORRECTION_DEFINES_SVH
`define SPLINE_EFFICIENCY_CORRECTION_DEFINES_SVH
`ifndef SYNTH
`define SEC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define SEC_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SEC_ASSERT(lbl, clk, rst_n, prop)
`define SEC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/sec_pkg.sv -----
// ----------------------------------------------------------------------------
// sec_pkg
// Types and constants of the spline efficiency correction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sec_pkg;
	localparam logic [63:0] SIGN64  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXPOS64 = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVER = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic CFG_NUM_KNOTS   = 1'b0;
	localparam logic CFG_LIST_LENGTH = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_FETCH,
		S_LOAD,
		S_MUL,
		S_MULW,
		S_ADD,
		S_DIV_START,
		S_DIV_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic         start;
		logic [47:0]  num;
		logic [63:0]  den;
	} div_req_t;

	typedef struct packed {
		logic         done;
		logic         busy;
		logic [63:0]  quot;
		logic         sat;
	} div_rsp_t;
endpackage

// ----- hw/rtl/sec_mul.sv -----
// ----------------------------------------------------------------------------
// sec_mul
// Sign-magnitude Q8.56 x Q16.16 multiply, four 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sec_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] res,
	output logic        sat
);
	logic [2:0]   step_q;
	logic         busy_q;
	logic [63:0]  am_q, dm_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [6:0]   sh;
	logic [127:0] rnd;
	logic [63:0]  rlo;
	logic [64:0]  lim;
	logic         ovf;

	always_comb begin
		pa = step_q[1] ? am_q[63:32] : am_q[31:0];
		pb = step_q[0] ? dm_q[63:32] : dm_q[31:0];
		pp = 64'(pa) * 64'(pb);
		sh = {1'b0, step_q[1], 5'd0} + {1'b0, step_q[0], 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[63] ? 64'(-a) : a;
			dm_q  <= d[63] ? 64'(-d) : d;
			neg_q <= a[63] ^ d[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (128'(pp) << sh);
		end
	end

	always_comb begin
		rnd = acc_q + 128'h8000;
		ovf = rnd[127:80] != '0;
		rlo = ovf ? sec_pkg::SIGN64 : rnd[79:16];
		lim = neg_q ? 65'(sec_pkg::SIGN64) : 65'(sec_pkg::MAXPOS64);
		sat = ovf || (65'(rlo) > lim);
		res = (65'(rlo) > lim) ? lim[63:0] : rlo;
		if (neg_q) res = 64'(-res);
	end
endmodule

// ----- hw/rtl/sec_div.sv -----
// ----------------------------------------------------------------------------
// sec_div
// Restoring divider, one quotient bit a cycle, 104-bit dividend area*2^56.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spline_efficiency_correction_defines.svh"
module sec_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sec_pkg::div_req_t  req,
	output sec_pkg::div_rsp_t  rsp
);
	logic [6:0]   cnt_q;
	logic         busy_q, done_q;
	logic [103:0] num_q;
	logic [63:0]  den_q;
	logic         neg_q;
	logic [64:0]  rem_q;
	logic [127:0] quo_q;
	logic [64:0]  rsh;
	logic [64:0]  diff;
	logic [64:0]  lim;
	logic [64:0]  ql;
	logic         ovf;

	always_comb begin
		rsh  = {rem_q[63:0], num_q[103]};
		diff = rsh - 65'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd103) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// top 24 dividend bits are zero, so 104 steps suffice
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {req.num, 56'd0};
			den_q <= req.den[63] ? 64'(-req.den) : req.den;
			neg_q <= req.den[63];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[102:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff;
				quo_q <= {quo_q[126:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[126:0], 1'b0};
			end
		end
	end

	always_comb begin
		ql  = 65'(quo_q[63:0]);
		if (rem_q >= 65'(den_q) - rem_q) ql = ql + 65'd1;
		ovf = (quo_q[127:64] != '0) || ql[64];
		if (ovf) ql = 65'(sec_pkg::SIGN64);
		lim = neg_q ? 65'(sec_pkg::SIGN64) : 65'(sec_pkg::MAXPOS64);
		rsp.sat = ovf || (ql > lim);
		if (ql > lim) ql = lim;
		rsp.quot = neg_q ? 64'(-ql[63:0]) : ql[63:0];
		rsp.done = done_q;
		rsp.busy = busy_q;
	end

	`SEC_ASSERT(a_div_done_end, clk, arst_n, done_q |-> $past(busy_q))
	`SEC_ASSERT(a_div_no_restart, clk, arst_n, (busy_q && cnt_q != 7'd103) |=> busy_q)
	`SEC_ASSERT(a_div_done_pulse, clk, arst_n, done_q |=> !done_q)
endmodule

// ----- hw/rtl/spline_efficiency_correction.sv -----
// Flow: load items write the knot store on accept; an evaluate item passes through knot search,
// fetch, three Horner multiply-add steps, two divides (area, then sigma) and output to m_tvalid.
// Over-limit peaks skip the arithmetic and go from idle straight to output.
// Throughput: one item at a time; ready is low while an evaluate item works or a result waits.
// Reset: arst_n resets state, counter, output valid and config; knot store and datapath are not cleared.
`timescale 1ns / 1ps
`include "spline_efficiency_correction_defines.svh"
module spline_efficiency_correction #(
	parameter int MAX_KNOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// knot_index, knot_energy, knot_efficiency, coef_first, coef_second,
	// coef_third, peak_energy, peak_area, peak_area_sigma, pad
	input  logic [423:0] s_tdata,
	input  logic         s_tuser,   // action
	input  logic         s_tlast,   // last_peak
	output logic         m_tvalid,
	input  logic         m_tready,
	// efficiency, intensity, intensity_sigma
	output logic [191:0] m_tdata,
	output logic [1:0]   m_tuser    // status
);
	localparam int IW = $clog2(MAX_KNOTS);
	localparam int CW = $clog2(MAX_KNOTS + 1);

	logic [31:0]  en_mem [MAX_KNOTS];
	logic [255:0] cf_mem [MAX_KNOTS];
	logic [5:0]   num_knots_q;
	logic [15:0]  list_len_q, cnt_q;
	sec_pkg::state_t st_q, st_d;

	logic [4:0]   k_idx;
	logic [31:0]  pe_q;
	logic [47:0]  ar_q, sg_q;
	logic         last_q, sat_q, over_q;
	logic [IW-1:0] i_q, ra_q, sel_q;
	logic [31:0]  rd_en_q, e0_q;
	logic [255:0] rd_cf_q;
	logic         have_e0_q, found_q, sig_q;
	logic [CW-1:0] n_eff;
	logic [1:0]   hs_q;
	logic [63:0]  acc_q, delta_q, eff_q, int_q, isg_q;
	logic [1:0]   rstat_q;
	logic [191:0] od_q;
	logic         ov_q;

	logic         mstart, mdone, msat;
	logic [63:0]  mres, addend;
	sec_pkg::div_req_t dreq;
	sec_pkg::div_rsp_t drsp;
	logic [64:0]  sum;
	logic         sum_ovf;

	assign k_idx = s_tdata[4:0];

	always_comb begin
		if (num_knots_q < 6'd2) n_eff = CW'(2);
		else if (32'(num_knots_q) > MAX_KNOTS) n_eff = CW'(MAX_KNOTS);
		else n_eff = CW'(num_knots_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_knots_q <= 6'd4;
			list_len_q  <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sec_pkg::CFG_NUM_KNOTS:   num_knots_q <= cfg_data[5:0];
				sec_pkg::CFG_LIST_LENGTH: list_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready && s_tuser == sec_pkg::ACT_LOAD
		    && 32'(k_idx) < MAX_KNOTS) begin
			en_mem[IW'(k_idx)] <= s_tdata[36:5];
			cf_mem[IW'(k_idx)] <= s_tdata[292:37];
		end
		rd_en_q <= en_mem[ra_q];
		rd_cf_q <= cf_mem[sel_q];
	end

	sec_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mstart), .a(acc_q), .d(delta_q),
		.done(mdone), .res(mres), .sat(msat));
	sec_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (st_q == sec_pkg::S_IDLE) && !ov_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sec_pkg::S_IDLE:
				if (s_tvalid && s_tready && s_tuser == sec_pkg::ACT_EVAL)
					st_d = (cnt_q >= list_len_q) ? sec_pkg::S_OUT : sec_pkg::S_SEARCH;
			sec_pkg::S_SEARCH:
				if (found_q) st_d = sec_pkg::S_FETCH;
			sec_pkg::S_FETCH: st_d = sec_pkg::S_LOAD;
			sec_pkg::S_LOAD:  st_d = sec_pkg::S_MUL;
			sec_pkg::S_MUL:   st_d = sec_pkg::S_MULW;
			sec_pkg::S_MULW:  if (mdone) st_d = sec_pkg::S_ADD;
			sec_pkg::S_ADD:
				if (hs_q != 2'd2) st_d = sec_pkg::S_MUL;
				else if (sum_ovf ? 1'b1 : sum[63:0] != '0) st_d = sec_pkg::S_DIV_START;
				else st_d = sec_pkg::S_OUT;
			sec_pkg::S_DIV_START: st_d = sec_pkg::S_DIV_WAIT;
			sec_pkg::S_DIV_WAIT:
				if (drsp.done) st_d = sig_q ? sec_pkg::S_OUT : sec_pkg::S_DIV_START;
			sec_pkg::S_OUT: st_d = sec_pkg::S_IDLE;
			default: st_d = sec_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mstart = st_q == sec_pkg::S_MUL;
		unique case (hs_q)
			2'd0: addend = rd_cf_q[191:128];
			2'd1: addend = rd_cf_q[127:64];
			default: addend = rd_cf_q[63:0];
		endcase
		sum = {mres[63], mres} + {addend[63], addend};
		sum_ovf = sum[64] != sum[63];
		if (sum_ovf) sum = addend[63] ? {1'b1, sec_pkg::SIGN64} : {1'b0, sec_pkg::MAXPOS64};
		dreq.start = st_q == sec_pkg::S_DIV_START;
		dreq.num   = sig_q ? sg_q : ar_q;
		dreq.den   = eff_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= sec_pkg::S_IDLE;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (m_tvalid && m_tready) ov_q <= 1'b0;
			if (st_q == sec_pkg::S_OUT) begin
				ov_q <= 1'b1;
				if (last_q) cnt_q <= '0;
				else if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == sec_pkg::S_OUT) begin
			od_q    <= {isg_q, int_q, eff_q};
			rstat_q <= over_q ? sec_pkg::ST_OVER : (sat_q ? sec_pkg::ST_SAT : sec_pkg::ST_OK);
		end
		unique case (st_q)
			sec_pkg::S_IDLE: begin
				pe_q <= s_tdata[324:293];
				ar_q <= s_tdata[372:325];
				sg_q <= s_tdata[420:373];
				last_q <= s_tlast;
				over_q <= cnt_q >= list_len_q;
				sat_q <= 1'b0;
				sig_q <= 1'b0;
				eff_q <= '0; int_q <= '0; isg_q <= '0;
				ra_q <= '0; i_q <= '0; sel_q <= '0;
				have_e0_q <= 1'b0; found_q <= 1'b0;
			end
			sec_pkg::S_SEARCH: begin
				// rd_en_q holds the entry that ra_q addressed in the previous cycle
				if (found_q) begin
					sel_q <= i_q; ra_q <= i_q;
				end else if (!have_e0_q) begin
					ra_q <= IW'(32'(ra_q) + 1);
					if (ra_q != '0) begin
						e0_q      <= rd_en_q;
						have_e0_q <= 1'b1;
						i_q       <= '0;
						if (pe_q < rd_en_q) found_q <= 1'b1;
					end
				end else if (pe_q >= e0_q && pe_q < rd_en_q) begin
					found_q <= 1'b1;
				end else if (32'(i_q) + 2 >= 32'(n_eff)) begin
					found_q <= 1'b1; i_q <= IW'(32'(n_eff) - 1);
				end else begin
					e0_q <= rd_en_q;
					i_q  <= IW'(32'(i_q) + 1);
					ra_q <= IW'(32'(ra_q) + 1);
				end
			end
			sec_pkg::S_FETCH: ;
			sec_pkg::S_LOAD: begin
				acc_q   <= rd_cf_q[255:192];
				delta_q <= 64'($signed({1'b0, pe_q}) - $signed({1'b0, rd_en_q}));
				hs_q    <= '0;
			end
			sec_pkg::S_ADD: begin
				acc_q <= sum[63:0];
				hs_q  <= hs_q + 2'd1;
				if (msat || sum_ovf) sat_q <= 1'b1;
				if (hs_q == 2'd2) eff_q <= sum[63:0];
			end
			sec_pkg::S_DIV_WAIT:
				if (drsp.done) begin
					if (drsp.sat) sat_q <= 1'b1;
					if (sig_q) isg_q <= drsp.quot; else int_q <= drsp.quot;
					sig_q <= 1'b1;
				end
			default: ;
		endcase
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = rstat_q;

	`SEC_ASSERT(a_busy_not_ready, clk, arst_n, (st_q != sec_pkg::S_IDLE) |-> !s_tready)
	`SEC_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid)
	`SEC_ASSERT(a_over_zero, clk, arst_n,
		(m_tvalid && m_tuser == sec_pkg::ST_OVER) |-> (m_tdata == '0))
endmodule
